### rtl/cslr_pkg.sv
// Shared types and fixed constants of the combined shuffled LCG generator.
package cslr_pkg;

    // Generator one: x <- MUL_A * x mod MOD_A, with MOD_A = 2^31 - FOLD_A
    localparam logic [31:0] MOD_A  = 32'd2147483563;
    localparam logic [15:0] MUL_A  = 16'd40014;
    localparam logic [7:0]  FOLD_A = 8'd85;

    // Generator two: y <- MUL_B * y mod MOD_B, with MOD_B = 2^31 - FOLD_B
    localparam logic [31:0] MOD_B  = 32'd2147483399;
    localparam logic [15:0] MUL_B  = 16'd40692;
    localparam logic [7:0]  FOLD_B = 8'd249;

    // Largest output value, also the wrap offset of the output difference
    localparam logic [31:0] TOP_OUT = 32'd2147483562;

    localparam logic [30:0] GEN_A_RESET = 31'd1;
    localparam logic [30:0] GEN_B_RESET = 31'd123456789;
    localparam logic [30:0] SEED_RESET  = 31'd999999999;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_seed;  // load both generators from the seed, preset warm-up count
        logic mul_a;      // multiply generator one only
        logic mul_both;   // multiply both generators, estimate the slot
        logic fold_warm;  // reduce generator one, fill a table slot during warm-up
        logic fold_draw;  // reduce both generators, fix the slot, read the table
        logic finish;     // form the output, write the slot back, load the output
    } cslr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic warm_last;  // warm-up count is at its final step
        logic out_free;   // output register can take a new result this cycle
    } cslr_sts_t;

endpackage

### rtl/combined_lcg_shuffle_rng_unit.sv
// Top level of the combined two-generator random source with shuffle table.
//
// Usage:
//   Slave channel (s_*): one transfer per requested number. s_tdata[0] is
//   reseed: 1 reloads both generators from the seed register and refills the
//   shuffle table before drawing, 0 only draws.
//   Master channel (m_*): one transfer per request, m_tdata[30:0] holds the
//   value, always in 1..2147483562.
//   Configuration: cfg_we writes cfg_wdata into the seed register (a seed of 0
//   acts as 1). Write only while the unit is idle.
// Steps:
//   A draw runs a multiply (31x16), then a modular fold plus shuffle table
//   read, then combine and write back. A reseed first loads the seed and
//   runs TABLE_SIZE+8 warm-up steps, each a multiply and fold of generator one.
//   A new item is taken once the previous result sits in the output register.
// Reset: rst_n asynchronously restores the generator start values, the seed
//   register, and marks every table slot empty (empty slots read as zero).
// Stall: while m_tready is low the result holds; the next item finishes its
//   work and then waits until the output register frees up.
module combined_lcg_shuffle_rng_unit #(
    parameter int TABLE_SIZE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side: [0] reseed, [7:1] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // master side: [30:0] random_value, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // seed register write
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata
);

    cslr_pkg::cslr_cmd_t cmd;
    cslr_pkg::cslr_sts_t sts;
    logic [30:0]         random_value;

    // sequence warm-up and draw steps
    cslr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_reseed (s_tdata[0]),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // generators, table and output register
    cslr_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (random_value)
    );

    // pad the value to whole bytes
    assign m_tdata = {1'b0, random_value};

endmodule

### rtl/cslr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cslr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cslr_ctrl.sv
// Sequencer for warm-up and draw steps of the shuffled generator.
module cslr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_reseed,
    output logic                in_ready,
    input  cslr_pkg::cslr_sts_t sts,
    output cslr_pkg::cslr_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WFOLD,
        ST_DMUL,
        ST_DFOLD,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_reseed)
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_WMUL;
                    end
                    else
                    begin
                        cmd.mul_both = 1'b1;
                        state_next   = ST_DFOLD;
                    end
                end
            end
            ST_WMUL:
            begin
                cmd.mul_a  = 1'b1;
                state_next = ST_WFOLD;
            end
            ST_WFOLD:
            begin
                cmd.fold_warm = 1'b1;
                state_next    = sts.warm_last ? ST_DMUL : ST_WMUL;
            end
            ST_DMUL:
            begin
                cmd.mul_both = 1'b1;
                state_next   = ST_DFOLD;
            end
            ST_DFOLD:
            begin
                cmd.fold_draw = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_draw_goes_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_reseed) |=> (state_reg == ST_DFOLD))
        else $error("draw transfer did not start the reduce step");

    a_warm_loops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WFOLD && !sts.warm_last) |=> (state_reg == ST_WMUL))
        else $error("warm-up left early");
`endif

endmodule

### rtl/cslr_datapath.sv
// Generators, slot divider, shuffle table and output register.
module cslr_datapath #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [30:0]         cfg_wdata,
    input  cslr_pkg::cslr_cmd_t cmd,
    output cslr_pkg::cslr_sts_t sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [30:0]         out_value
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int Q_W    = SLOT_W + 1;
    localparam int CNT_W  = $clog2(TABLE_SIZE + 8);

    // slot = last / SLOT_DIV, done as a reciprocal estimate plus one correction
    localparam logic [63:0] SLOT_DIV = 64'd1 + 64'(cslr_pkg::TOP_OUT) / 64'(TABLE_SIZE);
    localparam logic [63:0] RECIP    = (64'd1 << 31) / SLOT_DIV;
    localparam logic [31:0] DIV_V    = SLOT_DIV[31:0];
    localparam logic [Q_W-1:0] RECIP_V = RECIP[Q_W-1:0];

    localparam logic [CNT_W-1:0] WARM_START = CNT_W'(TABLE_SIZE + 7);
    localparam logic [CNT_W-1:0] CNT_TABLE  = CNT_W'(TABLE_SIZE);
    localparam logic [Q_W:0]     Q_TABLE    = (Q_W + 1)'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);

    logic [30:0]           seed_reg;
    logic [30:0]           first_gen_reg;
    logic [30:0]           second_gen_reg;
    logic [30:0]           last_output_reg;
    logic [TABLE_SIZE-1:0] valid_reg;
    logic                  out_valid_reg;

    logic [46:0]           prod_a_reg;
    logic [46:0]           prod_b_reg;
    logic [Q_W-1:0]        quot_est_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [CNT_W-1:0]      warm_cnt_reg;
    logic                  read_valid_reg;
    logic [30:0]           out_value_reg;

    logic [30:0]           gen_a_next;
    logic [30:0]           gen_b_next;
    logic [30:0]           seed_eff;
    logic [31+Q_W-1:0]     est_prod;
    logic [31+Q_W:0]       est_base;
    logic [31+Q_W:0]       est_rem;
    logic [Q_W:0]          quot_fix;
    logic [SLOT_W-1:0]     slot_next;
    logic                  warm_in_table;
    logic [30:0]           table_val;
    logic [31:0]           diff_val;
    logic [30:0]           result_val;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [30:0]           ram_wdata;
    logic [30:0]           ram_rdata;

    // a*x mod m for m = 2^31 - c: fold the bits above 31 back in times c
    function automatic logic [30:0] fold_mod(input logic [46:0] p,
                                             input logic [7:0]  c,
                                             input logic [31:0] m);
        logic [31:0] hi_part;
        logic [31:0] sum;
        logic [31:0] red;
        hi_part = {16'd0, p[46:31]} * {24'd0, c};
        sum     = {1'b0, p[30:0]} + hi_part;
        red     = (sum >= m) ? (sum - m) : sum;
        return red[30:0];
    endfunction

    assign gen_a_next = fold_mod(prod_a_reg, cslr_pkg::FOLD_A, cslr_pkg::MOD_A);
    assign gen_b_next = fold_mod(prod_b_reg, cslr_pkg::FOLD_B, cslr_pkg::MOD_B);

    assign seed_eff = (seed_reg == 31'd0) ? 31'd1 : seed_reg;

    // slot estimate is low by at most one
    assign est_prod = (31 + Q_W)'(last_output_reg) * (31 + Q_W)'(RECIP_V);
    assign est_base = (32 + Q_W)'(quot_est_reg) * (32 + Q_W)'(DIV_V);
    assign est_rem  = (32 + Q_W)'(last_output_reg) - est_base;

    always_comb
    begin
        quot_fix = {1'b0, quot_est_reg} + (Q_W + 1)'(est_rem >= (32 + Q_W)'(DIV_V));
        if (quot_fix >= Q_TABLE)
        begin
            slot_next = SLOT_LAST;
        end
        else
        begin
            slot_next = quot_fix[SLOT_W-1:0];
        end
    end

    assign warm_in_table = (warm_cnt_reg < CNT_TABLE);

    // an entry never written reads as zero
    assign table_val = read_valid_reg ? ram_rdata : 31'd0;

    always_comb
    begin
        if (table_val > second_gen_reg)
        begin
            diff_val = {1'b0, table_val} - {1'b0, second_gen_reg};
        end
        else
        begin
            diff_val = {1'b0, table_val} + cslr_pkg::TOP_OUT - {1'b0, second_gen_reg};
        end
        result_val = diff_val[30:0];
    end

    assign ram_we    = cmd.finish || (cmd.fold_warm && warm_in_table);
    assign ram_waddr = cmd.finish ? slot_reg : warm_cnt_reg[SLOT_W-1:0];
    assign ram_wdata = cmd.finish ? first_gen_reg : gen_a_next;

    cslr_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.fold_draw),
        .raddr (slot_next),
        .rdata (ram_rdata)
    );

    // architectural state with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= cslr_pkg::SEED_RESET;
            first_gen_reg   <= cslr_pkg::GEN_A_RESET;
            second_gen_reg  <= cslr_pkg::GEN_B_RESET;
            last_output_reg <= 31'd0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (cmd.load_seed)
            begin
                first_gen_reg  <= seed_eff;
                second_gen_reg <= seed_eff;
            end
            if (cmd.fold_warm)
            begin
                first_gen_reg <= gen_a_next;
                if (warm_cnt_reg == '0)
                begin
                    last_output_reg <= gen_a_next;
                end
            end
            if (cmd.fold_draw)
            begin
                first_gen_reg  <= gen_a_next;
                second_gen_reg <= gen_b_next;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.finish)
            begin
                last_output_reg <= result_val;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers, always loaded before use
    always_ff @(posedge clk)
    begin
        if (cmd.mul_a || cmd.mul_both)
        begin
            prod_a_reg <= {16'd0, first_gen_reg} * {31'd0, cslr_pkg::MUL_A};
        end
        if (cmd.mul_both)
        begin
            prod_b_reg   <= {16'd0, second_gen_reg} * {31'd0, cslr_pkg::MUL_B};
            quot_est_reg <= est_prod[31+Q_W-1:31];
        end
        if (cmd.load_seed)
        begin
            warm_cnt_reg <= WARM_START;
        end
        else if (cmd.fold_warm && warm_cnt_reg != '0)
        begin
            warm_cnt_reg <= warm_cnt_reg - CNT_W'(1);
        end
        if (cmd.fold_draw)
        begin
            slot_reg       <= slot_next;
            read_valid_reg <= valid_reg[slot_next];
        end
        if (cmd.finish)
        begin
            out_value_reg <= result_val;
        end
    end

    assign sts.warm_last = (warm_cnt_reg == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;

`ifndef NO_ASSERTIONS
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_value_reg != 31'd0 &&
                           {1'b0, out_value_reg} <= cslr_pkg::TOP_OUT))
        else $error("result outside 1..top");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result loaded over one not yet taken");

    a_gens_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold_draw |=> ({1'b0, first_gen_reg} < cslr_pkg::MOD_A &&
                           {1'b0, second_gen_reg} < cslr_pkg::MOD_B))
        else $error("generator not reduced below its modulus");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for the combined shuffled LCG random source: reseeds, draws, seed writes.
`timescale 1ns / 1ps

module tb;

    // Shuffle table size the unit is built with; the predictor uses the same.
    localparam int TBL_SIZE = 32;

    // Schrage factors of both generators: MOD = MUL * QUO + REM.
    localparam longint LCG1_MOD = 64'd2147483563;
    localparam longint LCG1_MUL = 64'd40014;
    localparam longint LCG1_QUO = 64'd53668;
    localparam longint LCG1_REM = 64'd12211;
    localparam longint LCG2_MOD = 64'd2147483399;
    localparam longint LCG2_MUL = 64'd40692;
    localparam longint LCG2_QUO = 64'd52774;
    localparam longint LCG2_REM = 64'd3791;

    // Previous output divided by this gives the table slot to read.
    localparam int SLOT_DIV = 1 + int'(cslr_pkg::TOP_OUT) / TBL_SIZE;

    // Warm-up of a reseed plus the draw pipeline, with some margin.
    localparam int SETTLE_CYCLES = 2 * (TBL_SIZE + 8) + 12;
    localparam int REPORT_LIMIT = 10;
    localparam longint TIMEOUT_CYCLES = 64'd1_500_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_wdata = 31'd0;

    // Predictor state: both generators, the last value and the shuffle table.
    logic [30:0] seed_reg;
    logic [30:0] gen_one;
    logic [30:0] gen_two;
    logic [30:0] prev_value;
    logic [30:0] mix_table [TBL_SIZE];

    // Values the unit owes us, oldest first.
    logic [30:0] expected_values [$];

    int  mismatch_count = 0;
    int  values_checked = 0;
    int  requests_sent = 0;
    int  reseeds_sent = 0;
    int  seed_writes = 0;
    int  rx_stall = 0;
    bit  no_idle = 1'b0;

    combined_lcg_shuffle_rng_unit #(
        .TABLE_SIZE (TBL_SIZE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("tb: timeout, %0d values still outstanding", expected_values.size());
        $display("tb: FAIL");
        $finish;
    end

    // Multiply by a constant modulo a modulus by Schrage's split, exact for any 31-bit x.
    function automatic logic [30:0] schrage_mul(input logic [30:0] x, input longint mul,
                                                input longint quo, input longint rem,
                                                input longint modulus);
        longint v;
        longint k;
        longint t;
        v = {33'd0, x};
        k = v / quo;
        t = mul * (v - k * quo) - k * rem;
        if (t < 0)
            t += modulus;
        return t[30:0];
    endfunction

    function automatic logic [30:0] step_gen_one(input logic [30:0] x);
        return schrage_mul(x, LCG1_MUL, LCG1_QUO, LCG1_REM, LCG1_MOD);
    endfunction

    function automatic logic [30:0] step_gen_two(input logic [30:0] x);
        return schrage_mul(x, LCG2_MUL, LCG2_QUO, LCG2_REM, LCG2_MOD);
    endfunction

    // Restore the predictor to the unit's reset state.
    function automatic void clear_predictor();
        seed_reg = cslr_pkg::SEED_RESET;
        gen_one = cslr_pkg::GEN_A_RESET;
        gen_two = cslr_pkg::GEN_B_RESET;
        prev_value = 31'd0;
        for (int i = 0; i < TBL_SIZE; i++)
            mix_table[i] = 31'd0;
    endfunction

    // Advance the predictor by one request and return the value it must produce.
    function automatic logic [30:0] predict_draw(input bit reseed);
        logic [30:0] start;
        int          slot;
        int          j;
        longint      diff;
        if (reseed)
        begin
            // A zero seed acts as one; warm up eight steps past a full table.
            start = (seed_reg == 31'd0) ? 31'd1 : seed_reg;
            gen_one = start;
            gen_two = start;
            for (j = TBL_SIZE + 7; j >= 0; j--)
            begin
                gen_one = step_gen_one(gen_one);
                if (j < TBL_SIZE)
                    mix_table[j] = gen_one;
            end
            prev_value = mix_table[0];
        end
        gen_one = step_gen_one(gen_one);
        gen_two = step_gen_two(gen_two);
        slot = prev_value / SLOT_DIV;
        if (slot >= TBL_SIZE)
            slot = TBL_SIZE - 1;
        diff = longint'({33'd0, mix_table[slot]}) - longint'({33'd0, gen_two});
        mix_table[slot] = gen_one;
        if (diff < 1)
            diff += longint'(cslr_pkg::TOP_OUT);
        prev_value = diff[30:0];
        return prev_value;
    endfunction

    // Idle length: mostly none, often short, rarely long.
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("tb: mismatch (%s) at %0t: expected %0d (0x%08h), got %0d (0x%08h)",
                     what, $realtime, want, want, got, got);
    endfunction

    // Result side: check every transfer against the oldest prediction,
    // then pick the next ready level (stall stretches of random length).
    always @(posedge clk)
    begin
        logic [30:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            values_checked++;
            if (expected_values.size() == 0)
                note_mismatch("unexpected value", 32'd0, m_tdata);
            else
            begin
                want = expected_values.pop_front();
                if (m_tdata !== {1'b0, want})
                    note_mismatch("random_value", {1'b0, want}, m_tdata);
            end
        end
        if (rx_stall > 0)
            rx_stall--;
        else if (!no_idle && $urandom_range(0, 4) == 0)
            rx_stall = pick_gap() + 1;
        m_tready <= (rx_stall == 0);
    end

    // Send one request; hold valid high across back-to-back transfers.
    task automatic send_request(input bit reseed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, reseed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Transfer taken at this edge: predict in acceptance order.
        expected_values.push_back(predict_draw(reseed));
        requests_sent++;
        if (reseed)
            reseeds_sent++;
    endtask

    // Drop valid, wait until every owed value has arrived, then let the unit settle.
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the seed register; only called while the unit is idle.
    task automatic write_seed(input logic [30:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        seed_reg = value;
        seed_writes++;
        cfg_we <= 1'b0;
    endtask

    // Draws straight out of reset (zeroed table), then a reseed from the reset seed.
    task automatic test_reset_draws();
        repeat (4) send_request(1'b0);
        send_request(1'b1);
    endtask

    // Seed corners: zero, one, all ones, both moduli, the top output, alternating bits.
    task automatic test_seed_corners();
        logic [30:0] corner_seeds [0:7];
        corner_seeds = '{31'd0, 31'd1, 31'h7FFF_FFFF, cslr_pkg::MOD_A[30:0],
                         cslr_pkg::MOD_B[30:0], cslr_pkg::TOP_OUT[30:0],
                         31'h2AAA_AAAA, 31'h5555_5555};
        for (int i = 0; i < 8; i++)
        begin
            drain_results(4);
            write_seed(corner_seeds[i]);
            send_request(1'b1);
            send_request(1'b0);
        end
    endtask

    // Long random streams under several seeds, occasional reseeds in between.
    task automatic test_random_streams();
        logic [30:0] seed;
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results(4);
            unique case (phase)
                0: seed = 31'd0;
                3: seed = 31'h7FFF_FFFF;
                5: seed = cslr_pkg::MOD_A[30:0];
                default: seed = 31'($urandom);
            endcase
            write_seed(seed);
            // Run a couple of phases at full rate on both sides.
            no_idle = (phase == 2 || phase == 6);
            send_request(1'b1);
            for (int k = 0; k < 145; k++)
            begin
                // Hold the sender once until the unit has delivered everything.
                if (phase == 1 && k == 70)
                    drain_results(2);
                send_request($urandom_range(0, 15) == 0);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        clear_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_draws();
        test_seed_corners();
        test_random_streams();

        drain_results(SETTLE_CYCLES);
        $display("tb: %0d requests (%0d reseeds) over %0d seed writes, %0d values checked",
                 requests_sent, reseeds_sent, seed_writes, values_checked);
        $display("tb: seed corners, draws from reset, back-to-back and stalled streams, %0d %s",
                 mismatch_count, "mismatches");
        if (mismatch_count == 0 && expected_values.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
